@@ rtl/wges_pkg.sv @@
// Package for the weighted graph edge store.
// Holds sizes, opcodes and the controller/datapath command and status structs.
package wges_pkg;

  localparam int NODES       = 16;
  localparam int NODE_BITS   = 4;
  localparam int WEIGHT_BITS = 32;
  localparam int ADDR_BITS   = 2 * NODE_BITS;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_ERASE = 3'd1;
  localparam logic [2:0] OP_QUERY = 3'd2;
  localparam logic [2:0] OP_LOWER = 3'd3;
  localparam logic [2:0] OP_UPPER = 3'd4;
  localparam logic [2:0] OP_ALL   = 3'd5;
  localparam logic [2:0] OP_COMP  = 3'd6;
  localparam logic [2:0] OP_RSVD  = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 rd;        // read edge (row, col)
    logic [NODE_BITS-1:0] row;
    logic [NODE_BITS-1:0] col;
    logic                 wr;        // write wdata at edge (row, col)
    logic [WEIGHT_BITS-1:0] wdata;
  } wges_cmd_t;

  // Status from the datapath: registered read data.
  typedef struct packed {
    logic [WEIGHT_BITS-1:0] rdata;
  } wges_sts_t;

endpackage

@@ rtl/wges_datapath.sv @@
// Datapath of the weighted graph edge store: the edge weight memory.
// Depends on wges_pkg. The store is cleared by a sweep from the controller.
module wges_datapath (
  input  logic               clk,
  input  wges_pkg::wges_cmd_t cmd,
  output wges_pkg::wges_sts_t sts
);

  logic [wges_pkg::WEIGHT_BITS-1:0] mem [wges_pkg::NODES*wges_pkg::NODES];
  logic [wges_pkg::ADDR_BITS-1:0]   addr;

  // The edge key is the ordered pair (smaller, larger).
  always_comb begin
    if (cmd.row < cmd.col) begin
      addr = {cmd.row, cmd.col};
    end else begin
      addr = {cmd.col, cmd.row};
    end
  end

  // One port: registered read and write, both allowed in the same cycle; a read returns the old word.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= cmd.wdata;
    end
    if (cmd.rd) begin
      sts.rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/wges_ctrl.sv @@
// Controller of the weighted graph edge store: sequencer for all operations.
// Depends on wges_pkg; drives wges_datapath through command and status structs.
module wges_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           opcode,
  input  logic [3:0]           node_a,
  input  logic [3:0]           node_b,
  input  logic [31:0]          add_weight,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          weight_value,
  output logic                 present,
  output logic [3:0]           neighbour,
  output logic                 none_found,
  output logic                 last_item,
  output wges_pkg::wges_cmd_t  cmd,
  input  wges_pkg::wges_sts_t  sts
);

  localparam int NB = wges_pkg::NODE_BITS;
  localparam int WB = wges_pkg::WEIGHT_BITS;
  localparam int N  = wges_pkg::NODES;
  localparam int AB = wges_pkg::ADDR_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RMW_RD, S_RMW_WAIT, S_Q_WAIT, S_SCAN, S_SCAN_LAST,
    S_PICK, S_EMIT, S_OUT
  } state_t;

  state_t          state;
  logic [2:0]      op;
  logic [NB-1:0]   a, b, cur, k;
  logic [AB:0]     clr;
  logic [31:0]     w;
  logic [N-1:0]    mask, visited, pending;
  logic            rd_d;
  logic [NB-1:0]   k_d;
  logic [WB:0]     sum;
  logic [NB-1:0]   first_pend;
  logic            hit;
  logic [N-1:0]    row_mask, keep, vis_n, pend_n;

  assign in_ready = (state == S_IDLE);
  assign sum = {1'b0, sts.rdata} + {1'b0, w};
  assign hit = rd_d && (sts.rdata != '0);

  // Row mask with the final read merged in, and the range kept for the list.
  always_comb begin
    row_mask = mask;
    if (hit) row_mask[k_d] = 1'b1;
    keep = '1;
    if (op == wges_pkg::OP_LOWER) begin
      keep = (N'(1) << a) - N'(1);
    end else if (op == wges_pkg::OP_UPPER) begin
      keep = ~((N'(1) << a) - N'(1));
    end
  end

  // Walk update: if the scanned row has any neighbour, mark the node visited and add its new neighbours.
  always_comb begin
    vis_n  = visited;
    pend_n = pending;
    if (mask != '0) begin
      vis_n  = visited | (N'(1) << cur);
      pend_n = (pending | mask) & ~vis_n;
    end
  end

  // Lowest pending node after the walk update.
  always_comb begin
    first_pend = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (pend_n[i]) first_pend = NB'(i);
    end
  end

  // Memory commands.
  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.wr  = !clr[AB];
        cmd.row = clr[AB-1:NB];
        cmd.col = clr[NB-1:0];
      end
      S_IDLE: begin
        cmd.rd  = in_valid;
        cmd.row = node_a;
        cmd.col = (opcode inside {wges_pkg::OP_ADD, wges_pkg::OP_ERASE,
                                  wges_pkg::OP_QUERY}) ? node_b : '0;
        cmd.wr  = in_valid && (opcode == wges_pkg::OP_ERASE);
      end
      S_RMW_WAIT: begin
        cmd.row   = a;
        cmd.col   = b;
        cmd.wr    = (w != '0);
        cmd.wdata = sum[WB] ? '1 : sum[WB-1:0];
      end
      S_SCAN: begin
        cmd.rd  = 1'b1;
        cmd.row = cur;
        cmd.col = k;
      end
      default: cmd = '0;
    endcase
  end

  // Sequencer with registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
      rd_d      <= 1'b0;
    end else begin
      rd_d <= (state == S_SCAN);
      case (state)
        S_CLEAR: begin
          // Clear one memory word per cycle, every (row, col) pair in turn.
          if (clr[AB]) begin
            state <= S_IDLE;
          end else begin
            clr <= clr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op <= opcode; a <= node_a; b <= node_b; w <= add_weight;
            mask <= '0; visited <= '0; pending <= '0;
            weight_value <= '0; present <= 1'b0; neighbour <= '0;
            none_found <= 1'b1; last_item <= 1'b1;
            cur <= node_a; k <= '0;
            case (opcode)
              wges_pkg::OP_ADD:   state <= S_RMW_WAIT;
              wges_pkg::OP_QUERY: state <= S_Q_WAIT;
              wges_pkg::OP_LOWER, wges_pkg::OP_UPPER, wges_pkg::OP_ALL,
              wges_pkg::OP_COMP:  state <= S_SCAN;
              default: begin
                state <= S_OUT; out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_RMW_WAIT: begin
          state <= S_OUT; out_valid <= 1'b1;
        end
        S_Q_WAIT: begin
          weight_value <= sts.rdata;
          present      <= (sts.rdata != '0);
          state <= S_OUT; out_valid <= 1'b1;
        end
        S_SCAN: begin
          // One edge read per cycle, its registered result seen in the next cycle.
          k_d <= k;
          if (hit) mask[k_d] <= 1'b1;
          k <= k + 1'b1;
          if (k == NB'(N - 1)) state <= S_SCAN_LAST;
        end
        S_SCAN_LAST: begin
          if (op == wges_pkg::OP_COMP) begin
            mask  <= row_mask;
            state <= S_PICK;
          end else begin
            mask  <= row_mask & keep;
            k     <= '0;
            state <= S_EMIT;
          end
        end
        S_PICK: begin
          // Merge the scanned row into the walk; scan the next pending node, or list the visited nodes.
          visited <= vis_n;
          k <= '0;
          if (pend_n != '0) begin
            cur     <= first_pend;
            pending <= pend_n;
            mask    <= '0;
            state   <= S_SCAN;
          end else begin
            pending <= '0;
            mask    <= vis_n;
            op      <= wges_pkg::OP_ALL;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Find the next set bit, one node per cycle while the output is not stalled.
          if (!out_valid || out_ready) begin
            if (mask == '0) begin
              out_valid <= 1'b1; none_found <= 1'b1; last_item <= 1'b1;
              neighbour <= '0; state <= S_OUT;
            end else if (mask[k]) begin
              logic [N-1:0] rest;
              rest = mask & ~(N'(1) << k);
              out_valid <= 1'b1; none_found <= 1'b0; neighbour <= k;
              last_item <= (rest == '0);
              mask <= rest;
              k <= k + 1'b1;
              if (rest == '0) state <= S_OUT;
            end else begin
              out_valid <= 1'b0;
              k <= k + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_last_none: assert property (@(posedge clk) disable iff (rst)
    (out_valid && none_found) |-> last_item) else $error("empty without last");
`endif

endmodule

@@ rtl/weighted_graph_edge_store.sv @@
// Top level of the weighted graph edge store.
// Depends on wges_pkg, wges_ctrl and wges_datapath.
//
//  channel | signals                                         | dir
//  in      | in_valid in_ready opcode node_a node_b add_weight | in
//  out     | out_valid out_ready weight_value present neighbour none_found last_item | out
//
// Add reads the edge and writes back the saturated sum; query reads the edge; erase and
// unknown codes go straight to the result. A list scans one row, then steps through the node
// indices up to the last member, one result per member (one result for an empty list).
// A component walk scans one row per reached node before emitting.
// After reset a sweep clears all 256 memory words while in_ready stays low.
// A stalled result holds the sequencer until it is taken.
module weighted_graph_edge_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [3:0]  node_a,
  input  logic [3:0]  node_b,
  input  logic [31:0] add_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] weight_value,
  output logic        present,
  output logic [3:0]  neighbour,
  output logic        none_found,
  output logic        last_item
);

  wges_pkg::wges_cmd_t cmd;
  wges_pkg::wges_sts_t sts;

  // Sequencer.
  wges_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .opcode, .node_a, .node_b, .add_weight,
    .out_valid, .out_ready, .weight_value, .present, .neighbour, .none_found,
    .last_item, .cmd, .sts
  );

  // Edge memory.
  wges_datapath u_dp (.clk, .cmd, .sts);

endmodule
